@@ hw/rtl/qgf_pkg.sv @@
`default_nettype none
package qgf_pkg;

  localparam int MAX_POINTS_DEF = 1024;

  // shared step unit
  localparam int NUM_W   = 70;
  localparam int QUO_W   = 66;
  localparam int DEN_W   = 36;
  localparam int REM_W   = 38;
  localparam int STEP_W  = 7;

  localparam logic [STEP_W-1:0] SQRT_STEPS = 7'd35;
  localparam logic [STEP_W-1:0] ACC_STEPS  = 7'd48;
  localparam logic [STEP_W-1:0] POT_STEPS  = 7'd66;

  // floor(h / 10) = (h * RECIP10) >> RECIP_SHIFT for any 32-bit h
  localparam logic signed [33:0] RECIP10     = 34'sh0CCCCCCCD;
  localparam int                 RECIP_SHIFT = 35;

  localparam logic [QUO_W-1:0] POT_CAP = 66'd1 << 62;

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [31:0] wx;
    logic [31:0] wy;
    logic [31:0] wz;
    logic [30:0] h;
    logic [27:0] tenth;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic              sqrt_mode;
    logic [STEP_W-1:0] steps;
  } ar_ctl_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] res;
    if (v > 66'sd2147483647) begin
      res = 32'h7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      res = 32'h80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/qgf_table.sv @@
`default_nettype none
module qgf_table #(
  parameter int MAX_POINTS = qgf_pkg::MAX_POINTS_DEF,
  parameter int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire qgf_pkg::entry_t wr_data,
  input  wire logic [AW-1:0]   rd_addr,
  output qgf_pkg::entry_t      rd_data
);

  qgf_pkg::entry_t mem [MAX_POINTS];
  qgf_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ hw/rtl/qgf_arith.sv @@
`default_nettype none
module qgf_arith (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire qgf_pkg::ar_ctl_t             ctl,
  input  wire logic [qgf_pkg::NUM_W-1:0]    num,
  input  wire logic [qgf_pkg::DEN_W-1:0]    den,
  output logic                              done,
  output logic [qgf_pkg::QUO_W-1:0]         quo
);

  logic                          busy_r;
  logic                          done_r;
  logic                          sqrt_r;
  logic [qgf_pkg::STEP_W-1:0]    cnt_r;
  logic [qgf_pkg::NUM_W-1:0]     num_r;
  logic [qgf_pkg::REM_W-1:0]     rem_r;
  logic [qgf_pkg::QUO_W-1:0]     q_r;
  logic [qgf_pkg::DEN_W-1:0]     den_r;

  logic [qgf_pkg::REM_W-1:0]     rem_s;
  logic [qgf_pkg::REM_W-1:0]     sub;
  logic [qgf_pkg::REM_W:0]       diff;
  logic                          ge;

  // one restoring step: divide brings one numerator bit, root brings two
  always_comb begin
    if (sqrt_r) begin
      rem_s = {rem_r[qgf_pkg::REM_W-3:0], num_r[qgf_pkg::NUM_W-1 -: 2]};
      sub   = {q_r[qgf_pkg::REM_W-3:0], 2'b01};
    end else begin
      rem_s = {rem_r[qgf_pkg::REM_W-2:0], num_r[qgf_pkg::NUM_W-1]};
      sub   = {{(qgf_pkg::REM_W-qgf_pkg::DEN_W){1'b0}}, den_r};
    end
    diff = {1'b0, rem_s} - {1'b0, sub};
    ge   = ~diff[qgf_pkg::REM_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      sqrt_r <= ctl.sqrt_mode;
      num_r  <= num;
      den_r  <= den;
      rem_r  <= '0;
      q_r    <= '0;
    end else if (busy_r) begin
      num_r <= sqrt_r ? {num_r[qgf_pkg::NUM_W-3:0], 2'b00}
                      : {num_r[qgf_pkg::NUM_W-2:0], 1'b0};
      rem_r <= ge ? diff[qgf_pkg::REM_W-1:0] : rem_s;
      q_r   <= {q_r[qgf_pkg::QUO_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule
`default_nettype wire

@@ hw/rtl/quadrature_gravity_field_eval_core.sv @@
`default_nettype none
// channel  | ports                                   | handshake
// ---------+-----------------------------------------+--------------------------------
// request  | in_cmd, in_entry_index, in_coord_*,     | taken when start & !busy
//          | in_weight_*, in_min_length             |
// result   | out_accel_x/y/z, out_field_potential   | out_valid, one cycle, no stall
// config   | psel penable pwrite paddr pwdata       | write on psel&penable&pwrite&~paddr[2]
//          | prdata pready                           | pready tied high
//
// a load request holds busy through the tenth-of-resolution multiply, then the table write
// a query holds busy while it walks n = min(point_count, MAX_POINTS) entries, and
// strobes its result in the cycle after busy ends; the per-entry time is set by the
// one-bit-per-cycle root/divide unit (35 root steps, three 48-step acceleration
// divides, one 66-step potential divide)
// busy is high for the whole request; the result strobe cannot be held off
// synchronous active-low reset clears control state and sets point_count to 1
// table contents are not cleared: entries must be loaded before a query reads them
module quadrature_gravity_field_eval_core #(
  parameter int MAX_POINTS = qgf_pkg::MAX_POINTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_cmd,
  input  wire logic [9:0]  in_entry_index,
  input  wire logic [31:0] in_coord_x,
  input  wire logic [31:0] in_coord_y,
  input  wire logic [31:0] in_coord_z,
  input  wire logic [31:0] in_weight_x,
  input  wire logic [31:0] in_weight_y,
  input  wire logic [31:0] in_weight_z,
  input  wire logic [30:0] in_min_length,
  // result channel
  output logic             out_valid,
  output logic [31:0]      out_accel_x,
  output logic [31:0]      out_accel_y,
  output logic [31:0]      out_accel_z,
  output logic [31:0]      out_field_potential,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam logic [16:0] MAXP = 17'(MAX_POINTS);

  // sequencer states
  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_LD_MUL  = 5'd1;
  localparam logic [4:0] ST_LD_WR   = 5'd2;
  localparam logic [4:0] ST_Q_INIT  = 5'd3;
  localparam logic [4:0] ST_RD      = 5'd4;
  localparam logic [4:0] ST_DIFF    = 5'd5;
  localparam logic [4:0] ST_SQ_MUL  = 5'd6;
  localparam logic [4:0] ST_SQ_ADD  = 5'd7;
  localparam logic [4:0] ST_SQRT_GO = 5'd8;
  localparam logic [4:0] ST_SQRT_WT = 5'd9;
  localparam logic [4:0] ST_AC_GO   = 5'd10;
  localparam logic [4:0] ST_AC_WT   = 5'd11;
  localparam logic [4:0] ST_DOT_MUL = 5'd12;
  localparam logic [4:0] ST_DOT_ADD = 5'd13;
  localparam logic [4:0] ST_POT_GO  = 5'd14;
  localparam logic [4:0] ST_POT_WT  = 5'd15;
  localparam logic [4:0] ST_NEXT    = 5'd16;
  localparam logic [4:0] ST_DONE    = 5'd17;

  logic [4:0] state_r, state_nxt;

  // config register
  logic [10:0] point_count_r;
  logic        cfg_wr;
  assign cfg_wr = psel & penable & pwrite & ~paddr[2];
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {21'd0, point_count_r};

  // latched request
  logic [9:0]  idx_r;
  logic [31:0] px_r, py_r, pz_r;
  logic [31:0] lwx_r, lwy_r, lwz_r;
  logic [30:0] lh_r;

  // datapath registers
  logic [16:0]        i_r;
  logic [16:0]        n_r;
  logic [1:0]         k_r;
  logic signed [32:0] d_r [3];
  logic signed [67:0] mul_r;
  logic [65:0]        sumsq_r;
  logic signed [65:0] net_r;
  logic [35:0]        da_r, dp_r;
  logic signed [63:0] acc_r [3];
  logic signed [64:0] pot_r;
  logic               out_valid_r;
  logic [31:0]        oax_r, oay_r, oaz_r, opot_r;

  // table
  qgf_pkg::entry_t tbl_wdata, tbl_rdata;
  logic            tbl_we;
  logic [16:0]     idx_ext;
  assign idx_ext = {7'd0, idx_r};

  always_comb begin
    tbl_wdata.cx    = px_r;
    tbl_wdata.cy    = py_r;
    tbl_wdata.cz    = pz_r;
    tbl_wdata.wx    = lwx_r;
    tbl_wdata.wy    = lwy_r;
    tbl_wdata.wz    = lwz_r;
    tbl_wdata.h     = lh_r;
    tbl_wdata.tenth = mul_r[qgf_pkg::RECIP_SHIFT +: 28];
  end

  // out-of-range loads are dropped
  assign tbl_we = (state_r == ST_LD_WR) && (idx_ext < MAXP);

  qgf_table #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (idx_ext[AW-1:0]),
    .wr_data (tbl_wdata),
    .rd_addr (i_r[AW-1:0]),
    .rd_data (tbl_rdata)
  );

  // per-axis views of the current entry
  logic signed [31:0] w_sel;
  logic signed [32:0] d_sel;
  always_comb begin
    case (k_r)
      2'd0:    w_sel = tbl_rdata.wx;
      2'd1:    w_sel = tbl_rdata.wy;
      default: w_sel = tbl_rdata.wz;
    endcase
    d_sel = d_r[k_r];
  end

  // shared multiplier, registered
  logic signed [33:0] mul_a, mul_b;
  always_comb begin
    case (state_r)
      ST_LD_MUL: begin
        mul_a = {3'd0, lh_r};
        mul_b = qgf_pkg::RECIP10;
      end
      ST_DOT_MUL: begin
        mul_a = {{2{w_sel[31]}}, w_sel};
        mul_b = {d_sel[32], d_sel};
      end
      default: begin
        mul_a = {d_sel[32], d_sel};
        mul_b = {d_sel[32], d_sel};
      end
    endcase
  end

  // root / divide unit
  qgf_pkg::ar_ctl_t             ar_ctl;
  logic [qgf_pkg::NUM_W-1:0]    ar_num;
  logic [qgf_pkg::DEN_W-1:0]    ar_den;
  logic                         ar_done;
  logic [qgf_pkg::QUO_W-1:0]    ar_quo;

  logic [31:0] w_mag;
  logic [65:0] net_mag;
  assign w_mag   = w_sel[31] ? 32'(-w_sel) : w_sel;
  assign net_mag = net_r[65] ? 66'(-net_r) : net_r;

  always_comb begin
    ar_ctl.start     = 1'b0;
    ar_ctl.sqrt_mode = 1'b0;
    ar_ctl.steps     = qgf_pkg::SQRT_STEPS;
    ar_num           = {4'd0, sumsq_r};
    ar_den           = da_r;
    case (state_r)
      ST_SQRT_GO: begin
        ar_ctl.start     = 1'b1;
        ar_ctl.sqrt_mode = 1'b1;
      end
      ST_AC_GO: begin
        // |w| * 2^16 left-aligned in the numerator
        ar_ctl.start = 1'b1;
        ar_ctl.steps = qgf_pkg::ACC_STEPS;
        ar_num       = {w_mag, 38'd0};
      end
      ST_POT_GO: begin
        ar_ctl.start = 1'b1;
        ar_ctl.steps = qgf_pkg::POT_STEPS;
        ar_num       = {net_mag, 4'd0};
        ar_den       = dp_r;
      end
      default: begin
      end
    endcase
  end

  qgf_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ar_ctl),
    .num   (ar_num),
    .den   (ar_den),
    .done  (ar_done),
    .quo   (ar_quo)
  );

  // denominators from the root: max(r, h) and max(r, h/10), floored at one lsb
  logic [34:0] root;
  logic [34:0] h_ext, t_ext, da_c, dp_c;
  always_comb begin
    root  = ar_quo[34:0];
    h_ext = {4'd0, tbl_rdata.h};
    t_ext = {7'd0, tbl_rdata.tenth};
    da_c  = (root > h_ext) ? root : h_ext;
    dp_c  = (root > t_ext) ? root : t_ext;
    if (da_c == 35'd0) da_c = 35'd1;
    if (dp_c == 35'd0) dp_c = 35'd1;
  end

  // potential term, capped
  logic [62:0]        pot_q;
  logic signed [64:0] pot_sum;
  logic signed [64:0] pot_cl;
  always_comb begin
    pot_q   = (ar_quo > qgf_pkg::POT_CAP) ? 63'(qgf_pkg::POT_CAP) : ar_quo[62:0];
    pot_sum = net_r[65] ? pot_r + $signed({2'b00, pot_q})
                        : pot_r - $signed({2'b00, pot_q});
    if (pot_sum > $signed(65'(qgf_pkg::POT_CAP))) begin
      pot_cl = $signed(65'(qgf_pkg::POT_CAP));
    end else if (pot_sum < -$signed(65'(qgf_pkg::POT_CAP))) begin
      pot_cl = -$signed(65'(qgf_pkg::POT_CAP));
    end else begin
      pot_cl = pot_sum;
    end
  end

  logic signed [63:0] acc_q;
  assign acc_q = $signed({16'd0, ar_quo[47:0]});

  logic [16:0] n_c;
  assign n_c = ({6'd0, point_count_r} > MAXP) ? MAXP : {6'd0, point_count_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (start) state_nxt = in_cmd ? ST_Q_INIT : ST_LD_MUL;
      ST_LD_MUL:  state_nxt = ST_LD_WR;
      ST_LD_WR:   state_nxt = ST_IDLE;
      ST_Q_INIT:  state_nxt = (n_c == 17'd0) ? ST_DONE : ST_RD;
      ST_RD:      state_nxt = ST_DIFF;
      ST_DIFF:    state_nxt = ST_SQ_MUL;
      ST_SQ_MUL:  state_nxt = ST_SQ_ADD;
      ST_SQ_ADD:  state_nxt = (k_r == 2'd2) ? ST_SQRT_GO : ST_SQ_MUL;
      ST_SQRT_GO: state_nxt = ST_SQRT_WT;
      ST_SQRT_WT: if (ar_done) state_nxt = ST_AC_GO;
      ST_AC_GO:   state_nxt = ST_AC_WT;
      ST_AC_WT:   if (ar_done) state_nxt = (k_r == 2'd2) ? ST_DOT_MUL : ST_AC_GO;
      ST_DOT_MUL: state_nxt = ST_DOT_ADD;
      ST_DOT_ADD: state_nxt = (k_r == 2'd2) ? ST_POT_GO : ST_DOT_MUL;
      ST_POT_GO:  state_nxt = ST_POT_WT;
      ST_POT_WT:  if (ar_done) state_nxt = ST_NEXT;
      ST_NEXT:    state_nxt = (i_r + 17'd1 == n_r) ? ST_DONE : ST_RD;
      ST_DONE:    state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      point_count_r <= 11'd1;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_DONE);
      if (cfg_wr) begin
        point_count_r <= pwdata[10:0];
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    if (state_r == ST_IDLE && start) begin
      idx_r <= in_entry_index;
      px_r  <= in_coord_x;
      py_r  <= in_coord_y;
      pz_r  <= in_coord_z;
      lwx_r <= in_weight_x;
      lwy_r <= in_weight_y;
      lwz_r <= in_weight_z;
      lh_r  <= in_min_length;
    end
    case (state_r)
      ST_Q_INIT: begin
        i_r    <= 17'd0;
        n_r    <= n_c;
        acc_r[0] <= '0;
        acc_r[1] <= '0;
        acc_r[2] <= '0;
        pot_r  <= '0;
      end
      ST_DIFF: begin
        // d = c - p, exact in 33 bits
        d_r[0]  <= $signed({tbl_rdata.cx[31], tbl_rdata.cx}) - $signed({px_r[31], px_r});
        d_r[1]  <= $signed({tbl_rdata.cy[31], tbl_rdata.cy}) - $signed({py_r[31], py_r});
        d_r[2]  <= $signed({tbl_rdata.cz[31], tbl_rdata.cz}) - $signed({pz_r[31], pz_r});
        k_r     <= 2'd0;
        sumsq_r <= '0;
        net_r   <= '0;
      end
      ST_SQ_ADD: begin
        sumsq_r <= sumsq_r + mul_r[65:0];
        k_r     <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
      end
      ST_SQRT_WT: if (ar_done) begin
        da_r <= {1'b0, da_c};
        dp_r <= {1'b0, dp_c};
      end
      ST_AC_WT: if (ar_done) begin
        // truncation toward zero; accel accumulates the negated term
        acc_r[k_r] <= w_sel[31] ? acc_r[k_r] + acc_q : acc_r[k_r] - acc_q;
        k_r        <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
      end
      ST_DOT_ADD: begin
        net_r <= net_r + mul_r[65:0];
        k_r   <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
      end
      ST_POT_WT: if (ar_done) begin
        pot_r <= pot_cl;
      end
      ST_NEXT: begin
        i_r <= i_r + 17'd1;
      end
      ST_DONE: begin
        oax_r  <= qgf_pkg::sat32(66'(acc_r[0]));
        oay_r  <= qgf_pkg::sat32(66'(acc_r[1]));
        oaz_r  <= qgf_pkg::sat32(66'(acc_r[2]));
        // halving rounds toward minus infinity
        opot_r <= qgf_pkg::sat32(66'(pot_r >>> 1));
      end
      default: begin
      end
    endcase
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_accel_x         = oax_r;
  assign out_accel_y         = oay_r;
  assign out_accel_z         = oaz_r;
  assign out_field_potential = opot_r;

endmodule
`default_nettype wire

@@ tb/sv/field_checker.sv @@
`timescale 1ns / 1ps
module field_checker #(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        in_cmd,
  input  wire logic [9:0]  in_entry_index,
  input  wire logic [31:0] in_coord_x,
  input  wire logic [31:0] in_coord_y,
  input  wire logic [31:0] in_coord_z,
  input  wire logic [31:0] in_weight_x,
  input  wire logic [31:0] in_weight_y,
  input  wire logic [31:0] in_weight_z,
  input  wire logic [30:0] in_min_length,
  input  wire logic        out_valid,
  input  wire logic [31:0] out_accel_x,
  input  wire logic [31:0] out_accel_y,
  input  wire logic [31:0] out_accel_z,
  input  wire logic [31:0] out_field_potential,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               fail_count,
  output int               pending
);
  localparam logic [2:0] ADDR_POINT_COUNT = 3'd0;
  localparam logic       CMD_LOAD         = 1'b0;

  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
    logic [31:0] pot;
  } field_t;

  logic [31:0] cx_mem [MAX_POINTS];
  logic [31:0] cy_mem [MAX_POINTS];
  logic [31:0] cz_mem [MAX_POINTS];
  logic [31:0] wx_mem [MAX_POINTS];
  logic [31:0] wy_mem [MAX_POINTS];
  logic [31:0] wz_mem [MAX_POINTS];
  logic [30:0] h_mem  [MAX_POINTS];
  logic [10:0] walk_count;
  field_t      pending_fields [$];

  function automatic logic [34:0] isqrt(input logic [69:0] v);
    logic [34:0] res;
    logic [69:0] c;
    res = '0;
    for (int b = 34; b >= 0; b--) begin
      c = 70'(res | (35'd1 << b));
      if (c * c <= v) res = c[34:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [127:0] v);
    logic [31:0] res;
    if (v > 128'sd2147483647) res = 32'h7FFFFFFF;
    else if (v < -128'sd2147483648) res = 32'h80000000;
    else res = v[31:0];
    return res;
  endfunction

  function automatic field_t eval_field(input logic [31:0] px, input logic [31:0] py,
                                        input logic [31:0] pz);
    field_t f;
    int unsigned n;
    longint dx, dy, dz, wx, wy, wz, da, dp, rr, hh, tenth;
    longint ax, ay, az;
    logic signed [127:0] dxw, dyw, dzw, dot, mag, q, pot, cap, sq;
    ax = 0; ay = 0; az = 0; pot = 0;
    cap = 128'sd1 <<< 62;
    n = (walk_count > MAX_POINTS) ? MAX_POINTS : walk_count;
    for (int i = 0; i < n; i++) begin
      dx = longint'($signed(cx_mem[i])) - longint'($signed(px));
      dy = longint'($signed(cy_mem[i])) - longint'($signed(py));
      dz = longint'($signed(cz_mem[i])) - longint'($signed(pz));
      wx = longint'($signed(wx_mem[i]));
      wy = longint'($signed(wy_mem[i]));
      wz = longint'($signed(wz_mem[i]));
      hh = longint'(h_mem[i]);
      dxw = dx; dyw = dy; dzw = dz;
      sq = dxw * dxw + dyw * dyw + dzw * dzw;
      rr = longint'(isqrt(sq[69:0]));
      tenth = hh / 10;
      da = (rr > hh) ? rr : hh;
      dp = (rr > tenth) ? rr : tenth;
      if (da == 0) da = 1;
      if (dp == 0) dp = 1;
      ax -= (wx * 65536) / da;
      ay -= (wy * 65536) / da;
      az -= (wz * 65536) / da;
      dot = 128'(wx) * dxw + 128'(wy) * dyw + 128'(wz) * dzw;
      mag = (dot < 0) ? -dot : dot;
      q = mag / 128'(dp);
      if (q > cap) q = cap;
      if (dot >= 0) pot -= q;
      else pot += q;
      if (pot > cap) pot = cap;
      if (pot < -cap) pot = -cap;
    end
    f.ax  = sat32(128'(ax));
    f.ay  = sat32(128'(ay));
    f.az  = sat32(128'(az));
    f.pot = sat32(pot >>> 1);
    return f;
  endfunction

  assign pending = pending_fields.size();

  always @(posedge clk) begin
    field_t e;
    if (!rst_n) begin
      walk_count <= 11'd1;
    end else begin
      if (out_valid) begin
        if (pending_fields.size() == 0) begin
          $display("%0t: unexpected result ax=%h ay=%h az=%h pot=%h", $time,
                   out_accel_x, out_accel_y, out_accel_z, out_field_potential);
          fail_count++;
        end else begin
          e = pending_fields.pop_front();
          if (out_accel_x !== e.ax) begin
            $display("%0t: accel_x expected %h actual %h", $time, e.ax, out_accel_x);
            fail_count++;
          end
          if (out_accel_y !== e.ay) begin
            $display("%0t: accel_y expected %h actual %h", $time, e.ay, out_accel_y);
            fail_count++;
          end
          if (out_accel_z !== e.az) begin
            $display("%0t: accel_z expected %h actual %h", $time, e.az, out_accel_z);
            fail_count++;
          end
          if (out_field_potential !== e.pot) begin
            $display("%0t: potential expected %h actual %h", $time, e.pot,
                     out_field_potential);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        if (in_cmd == CMD_LOAD) begin
          if (in_entry_index < MAX_POINTS) begin
            cx_mem[in_entry_index] = in_coord_x;
            cy_mem[in_entry_index] = in_coord_y;
            cz_mem[in_entry_index] = in_coord_z;
            wx_mem[in_entry_index] = in_weight_x;
            wy_mem[in_entry_index] = in_weight_y;
            wz_mem[in_entry_index] = in_weight_z;
            h_mem[in_entry_index]  = in_min_length;
          end
        end else begin
          pending_fields.push_back(eval_field(in_coord_x, in_coord_y, in_coord_z));
        end
      end
      if (psel && penable && pwrite && pready && paddr == ADDR_POINT_COUNT)
        walk_count <= pwdata[10:0];
    end
  end
endmodule

@@ tb/sv/tb_quadrature_gravity_field_eval_core.sv @@
`timescale 1ns / 1ps
module tb_quadrature_gravity_field_eval_core;
  localparam logic [2:0] ADDR_POINT_COUNT = 3'd0;
  localparam logic       CMD_LOAD         = 1'b0;
  localparam logic       CMD_QUERY        = 1'b1;
  // entries 0..PREFIX-1 are always loaded before the random phase
  localparam int         PREFIX           = 16;
  // entries 0..WIDE-1 are loaded before the closing queries
  localparam int         WIDE             = 48;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_cmd;
  logic [9:0]  in_entry_index;
  logic [31:0] in_coord_x, in_coord_y, in_coord_z;
  logic [31:0] in_weight_x, in_weight_y, in_weight_z;
  logic [30:0] in_min_length;
  logic        out_valid;
  logic [31:0] out_accel_x, out_accel_y, out_accel_z, out_field_potential;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          load_total;
  int          query_total;
  int          burst_left;

  quadrature_gravity_field_eval_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_entry_index(in_entry_index),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .in_weight_x(in_weight_x), .in_weight_y(in_weight_y), .in_weight_z(in_weight_z),
    .in_min_length(in_min_length),
    .out_valid(out_valid), .out_accel_x(out_accel_x), .out_accel_y(out_accel_y),
    .out_accel_z(out_accel_z), .out_field_potential(out_field_potential),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // checker watches both channels and the config port
  field_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_entry_index(in_entry_index),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .in_weight_x(in_weight_x), .in_weight_y(in_weight_y), .in_weight_z(in_weight_z),
    .in_min_length(in_min_length),
    .out_valid(out_valid), .out_accel_x(out_accel_x), .out_accel_y(out_accel_y),
    .out_accel_z(out_accel_z), .out_field_potential(out_field_potential),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // random Q16.16 value: full range, small magnitude, extremes or within 16 lsb of zero
  function automatic logic [31:0] rand_q();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0, 1:    v = $urandom;
      2, 3:    v = 32'($urandom_range(0, 32'h007FFFFF)) - 32'h00400000;
      4:       v = ($urandom_range(0, 1) != 0) ? 32'h7FFFFFFF : 32'h80000000;
      default: v = 32'($urandom_range(0, 32)) - 32'd16;
    endcase
    return v;
  endfunction

  function automatic logic [30:0] rand_h();
    logic [30:0] v;
    case ($urandom_range(0, 4))
      0:       v = 31'($urandom);
      1:       v = 31'd1;
      2:       v = 31'h7FFFFFFF;
      3:       v = 31'($urandom_range(1, 9));
      default: v = 31'($urandom_range(1, 32'h00FFFFFF));
    endcase
    return v;
  endfunction

  // called at a clock edge; returns when the request is taken or after a gap that follows it
  task automatic send(input logic cmd, input logic [9:0] idx,
                      input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
                      input logic [31:0] wx, input logic [31:0] wy,
                      input logic [31:0] wz, input logic [30:0] h);
    start          <= 1'b1;
    in_cmd         <= cmd;
    in_entry_index <= idx;
    in_coord_x     <= x;
    in_coord_y     <= y;
    in_coord_z     <= z;
    in_weight_x    <= wx;
    in_weight_y    <= wy;
    in_weight_z    <= wz;
    in_min_length  <= h;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cmd == CMD_LOAD) load_total++;
    else query_total++;
    // bursts of back-to-back requests, random gaps between them
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 6);
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
  endtask

  task automatic load_entry(input logic [9:0] idx);
    send(CMD_LOAD, idx, rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
         rand_h());
  endtask

  task automatic query(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    send(CMD_QUERY, 10'($urandom), x, y, z, $urandom, $urandom, $urandom,
         31'($urandom));
  endtask

  // wait for the block to finish, then write point_count over the config port
  task automatic set_count(input logic [10:0] n);
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_POINT_COUNT;
    pwdata  <= {21'($urandom_range(0, 32'h001FFFFF)), n};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_LOAD;
    in_entry_index = '0;
    in_coord_x = '0; in_coord_y = '0; in_coord_z = '0;
    in_weight_x = '0; in_weight_y = '0; in_weight_z = '0;
    in_min_length = 31'd1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    load_total = 0;
    query_total = 0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // count zero: every output is zero, no table read
    set_count(11'd0);
    query(32'h7FFFFFFF, 32'h80000000, 32'h0);

    // directed loads of the first prefix entries with extreme contents, random loads for the rest
    send(CMD_LOAD, 10'd0, 32'h0, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h80000000,
         32'h00010000, 31'd1);
    send(CMD_LOAD, 10'd1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
         32'h80000000, 32'h80000000, 31'h7FFFFFFF);
    send(CMD_LOAD, 10'd2, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
         32'h7FFFFFFF, 32'h7FFFFFFF, 31'd9);
    for (int i = 3; i < PREFIX; i++) load_entry(10'(i));

    // one entry: centroid on the point gives a zero denominator
    set_count(11'd1);
    query(32'h0, 32'h0, 32'h0);
    query(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    set_count(11'd3);
    query(32'h0, 32'h0, 32'h0);
    query(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    query(32'h80000000, 32'h80000000, 32'h80000000);
    set_count(11'(PREFIX));
    query(rand_q(), rand_q(), rand_q());

    // random phase: mostly loads inside the prefix and queries over it
    for (int k = 0; k < 480; k++) begin
      if (k % 40 == 39) set_count(($urandom_range(0, 9) == 0) ? 11'd0
                                  : 11'($urandom_range(1, 8)));
      case ($urandom_range(0, 9))
        0, 1, 2: load_entry(10'($urandom_range(0, PREFIX - 1)));
        3:       load_entry(10'($urandom));
        default: query(rand_q(), rand_q(), rand_q());
      endcase
    end

    // wider table: fill past the prefix and walk all of it
    for (int i = PREFIX; i < WIDE; i++) load_entry(10'(i));
    set_count(11'(WIDE));
    query(rand_q(), rand_q(), rand_q());
    query(rand_q(), rand_q(), rand_q());
    query(32'h0, 32'h0, 32'h0);

    start <= 1'b0;
    @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d loads and %0d queries over counts 0 to %0d",
             load_total, query_total, WIDE);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #60ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end
endmodule
